// ===== hdl/sem_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sem_pkg;

   localparam int PIX_W        = 8;
   localparam int RGB_W        = 24;
   localparam int CFG_W_W      = 11;
   localparam int CFG_H_W      = 12;
   localparam int ROW_W        = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;
   localparam int SUM_W        = 23;
   localparam int ROOT_STEPS   = 12;
   localparam int ITER_W       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic load;
      logic mem_rd;
      logic step;
      logic calc;
      logic iter;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic in_frame;
      logic hit;
      logic out_full;
   } status_type;

endpackage

// ===== hdl/sem_req_if.sv =====
// Input channel of the Sobel edge magnitude block: handshake and pixel word.
// Depends on nothing.
interface sem_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

// ===== hdl/sem_rsp_if.sv =====
// Result channel of the Sobel edge magnitude block: handshake and edge word.
// Depends on nothing.
interface sem_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_edge;
   logic [7:0] green_edge;
   logic [7:0] blue_edge;
   logic       frame_last;

   modport source (output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
   modport sink (input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

// ===== hdl/sem_ctrl.sv =====
// Controller of the Sobel edge magnitude block: sequences each input word.
// Depends on sem_pkg.
module sem_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  sem_pkg::status_type  status,
   output sem_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_STEP,
      S_EVAL,
      S_CALC,
      S_ROOT,
      S_FIN
   } state_type;

   localparam logic [sem_pkg::ITER_W-1:0] ITER_ONE  = sem_pkg::ITER_W'(1);
   localparam logic [sem_pkg::ITER_W-1:0] ITER_LAST = sem_pkg::ITER_W'(sem_pkg::ROOT_STEPS - 1);

   state_type                    state_ff;
   logic [1:0]                   tries_ff;
   logic [sem_pkg::ITER_W-1:0]   iter_ff;
   logic                         flush_ff;
   logic                         accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd        = '0;
      cmd.load   = accept && !(status.in_frame && req_kind);
      cmd.mem_rd = (state_ff == S_READ);
      cmd.step   = (state_ff == S_STEP);
      cmd.calc   = (state_ff == S_CALC);
      cmd.iter   = (state_ff == S_ROOT);
      cmd.finish = (state_ff == S_FIN) && !status.out_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tries_ff <= '0;
         iter_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.load) begin
                  flush_ff <= !status.in_frame;
                  tries_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_STEP;
            end
            S_STEP: begin
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (status.hit) begin
                  state_ff <= S_CALC;
               end else if (flush_ff && (tries_ff != 2'd2)) begin
                  tries_ff <= tries_ff + 2'd1;
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_CALC: begin
               iter_ff  <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               iter_ff <= iter_ff + ITER_ONE;
               if (iter_ff == ITER_LAST) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!status.out_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("controller issued more than one command");

endmodule

// ===== hdl/sem_datapath.sv =====
// Datapath of the Sobel edge magnitude block: line stores, 3x3 window,
// gradient sums, per-color square root lanes and the result register. Uses sem_pkg.
module sem_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sem_pkg::cmd_type                   cmd,
   output sem_pkg::status_type                status,
   input  logic                               csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [sem_pkg::PIX_W-1:0]          req_red,
   input  logic [sem_pkg::PIX_W-1:0]          req_green,
   input  logic [sem_pkg::PIX_W-1:0]          req_blue,
   sem_rsp_if.source                          rsp_chan
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (WW > sem_pkg::CFG_W_W) ? WW : sem_pkg::CFG_W_W;
   localparam int RW = sem_pkg::ROW_W;
   localparam int HW = sem_pkg::CFG_H_W;
   localparam int SW = sem_pkg::SUM_W;
   localparam logic [SW-1:0] BIT_TOP = SW'(1) << (SW - 1);

   logic [sem_pkg::CFG_W_W-1:0] width_ff;
   logic [HW-1:0]               height_ff;
   logic [CW-1:0]               col_ff;
   logic [RW-1:0]               row_ff;
   logic [sem_pkg::RGB_W-1:0]   win_ff [9];
   logic [sem_pkg::RGB_W-1:0]   tap_ff [9];
   logic [sem_pkg::RGB_W-1:0]   pix_ff;
   logic [sem_pkg::RGB_W-1:0]   up_rd_ff;
   logic [sem_pkg::RGB_W-1:0]   mid_rd_ff;
   logic [sem_pkg::RGB_W-1:0]   upper_mem  [MAX_WIDTH];
   logic [sem_pkg::RGB_W-1:0]   middle_mem [MAX_WIDTH];
   logic                        hit_ff;
   logic                        last_ff;
   logic [SW-1:0]               rem_ff  [3];
   logic [SW-1:0]               root_ff [3];
   logic [SW-1:0]               bit_ff;
   logic                        out_valid_ff;
   logic                        out_last_ff;
   logic [sem_pkg::PIX_W-1:0]   out_ff [3];

   logic [XW-1:0]               width_x;
   logic [WW-1:0]               eff_w;
   logic [WW-1:0]               wm1;
   logic [HW-1:0]               eff_h;
   logic                        c0;
   logic                        hit_in;
   logic                        last_in;
   logic [RW-1:0]               orow;
   logic [CW-1:0]               ocol;
   logic                        top_e, bot_e, left_e, right_e;
   logic [WW-1:0]               col_nx;
   logic [sem_pkg::RGB_W-1:0]   nw_in  [9];
   logic [sem_pkg::RGB_W-1:0]   tap_in [9];
   logic [SW-1:0]               sum_in [3];
   logic [SW-1:0]               rem_in [3];
   logic [SW-1:0]               root_in [3];
   logic [sem_pkg::PIX_W-1:0]   mag_in [3];
   logic                        rsp_take;

   // Effective frame size: width clamped to 1..MAX_WIDTH, height zero taken as one.
   always_comb begin
      width_x = XW'(width_ff);
      if (width_x == '0) begin
         width_x = XW'(1);
      end else if (width_x > XW'(MAX_WIDTH)) begin
         width_x = XW'(MAX_WIDTH);
      end
      eff_w = width_x[WW-1:0];
      wm1   = eff_w - WW'(1);
      eff_h = (height_ff == '0) ? HW'(1) : height_ff;
   end

   assign status.in_frame = (row_ff < RW'(eff_h));
   assign status.hit      = hit_ff;
   assign status.out_full = out_valid_ff;

   // Window advance, output position and border masking for one stream position.
   always_comb begin
      c0      = (col_ff == '0);
      col_nx  = WW'(col_ff) + WW'(1);
      if (c0) begin
         hit_in = (row_ff >= RW'(2)) && (row_ff <= RW'(eff_h) + RW'(1));
         orow   = row_ff - RW'(2);
         ocol   = wm1[CW-1:0];
      end else begin
         hit_in = (row_ff >= RW'(1)) && (row_ff <= RW'(eff_h));
         orow   = row_ff - RW'(1);
         ocol   = col_ff - CW'(1);
      end
      top_e   = (orow == '0);
      bot_e   = (orow == RW'(eff_h) - RW'(1));
      left_e  = (ocol == '0);
      right_e = (WW'(ocol) == wm1);
      last_in = bot_e && right_e;
      for (int k = 0; k < 3; k++) begin
         nw_in[k*3]   = win_ff[k*3+1];
         nw_in[k*3+1] = win_ff[k*3+2];
      end
      nw_in[2] = up_rd_ff;
      nw_in[5] = mid_rd_ff;
      nw_in[8] = pix_ff;
      for (int k = 0; k < 9; k++) begin
         if (c0) begin
            tap_in[k] = ((k % 3) == 2) ? '0 : win_ff[k+1];
         end else begin
            tap_in[k] = nw_in[k];
         end
         if (((k / 3) == 0 && top_e) || ((k / 3) == 2 && bot_e) ||
             ((k % 3) == 0 && left_e) || ((k % 3) == 2 && right_e)) begin
            tap_in[k] = '0;
         end
      end
   end

   // Gradients and squared magnitude, one lane per color.
   always_comb begin
      logic [10:0] pos_x, neg_x, pos_y, neg_y;
      logic [11:0] gx, gy;
      logic [10:0] ax, ay;
      for (int l = 0; l < 3; l++) begin
         pos_x = 11'(tap_ff[2][(2-l)*8 +: 8]) + {2'b0, tap_ff[5][(2-l)*8 +: 8], 1'b0}
               + 11'(tap_ff[8][(2-l)*8 +: 8]);
         neg_x = 11'(tap_ff[0][(2-l)*8 +: 8]) + {2'b0, tap_ff[3][(2-l)*8 +: 8], 1'b0}
               + 11'(tap_ff[6][(2-l)*8 +: 8]);
         pos_y = 11'(tap_ff[6][(2-l)*8 +: 8]) + {2'b0, tap_ff[7][(2-l)*8 +: 8], 1'b0}
               + 11'(tap_ff[8][(2-l)*8 +: 8]);
         neg_y = 11'(tap_ff[0][(2-l)*8 +: 8]) + {2'b0, tap_ff[1][(2-l)*8 +: 8], 1'b0}
               + 11'(tap_ff[2][(2-l)*8 +: 8]);
         gx = {1'b0, pos_x} - {1'b0, neg_x};
         gy = {1'b0, pos_y} - {1'b0, neg_y};
         ax = gx[11] ? 11'(-gx) : gx[10:0];
         ay = gy[11] ? 11'(-gy) : gy[10:0];
         sum_in[l] = SW'(22'(ax) * 22'(ax)) + SW'(22'(ay) * 22'(ay));
      end
   end

   // One digit pair of the restoring square root per lane, then rounding.
   always_comb begin
      logic [SW:0]   trial;
      logic [SW-1:0] rounded;
      for (int l = 0; l < 3; l++) begin
         trial = {1'b0, root_ff[l]} + {1'b0, bit_ff};
         if ({1'b0, rem_ff[l]} >= trial) begin
            rem_in[l]  = rem_ff[l] - trial[SW-1:0];
            root_in[l] = (root_ff[l] >> 1) + bit_ff;
         end else begin
            rem_in[l]  = rem_ff[l];
            root_in[l] = root_ff[l] >> 1;
         end
         rounded = root_ff[l] + SW'(rem_ff[l] > root_ff[l]);
         mag_in[l] = (rounded > SW'(255)) ? 8'hff : rounded[7:0];
      end
   end

   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WIDTH_RESET;
         height_ff <= sem_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            sem_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[sem_pkg::CFG_W_W-1:0];
            sem_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
         col_ff <= '0;
         row_ff <= '0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (cmd.step) begin
         if (hit_in && last_in) begin
            col_ff <= '0;
            row_ff <= '0;
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= '0;
            end
         end else begin
            if (col_nx >= eff_w) begin
               col_ff <= '0;
               row_ff <= row_ff + RW'(1);
            end else begin
               col_ff <= col_nx[CW-1:0];
            end
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= nw_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (cmd.step) begin
         upper_mem[col_ff]  <= mid_rd_ff;
         middle_mem[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff <= status.in_frame ? {req_red, req_green, req_blue} : '0;
      end
      if (cmd.step) begin
         tap_ff  <= tap_in;
         last_ff <= last_in;
      end
      if (cmd.calc) begin
         bit_ff <= BIT_TOP;
         for (int l = 0; l < 3; l++) begin
            rem_ff[l]  <= sum_in[l];
            root_ff[l] <= '0;
         end
      end else if (cmd.iter) begin
         bit_ff <= bit_ff >> 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.finish) begin
         out_ff      <= mag_in;
         out_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            hit_ff <= hit_in;
         end
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.red_edge   = out_ff[0];
   assign rsp_chan.green_edge = out_ff[1];
   assign rsp_chan.blue_edge  = out_ff[2];
   assign rsp_chan.frame_last = out_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !out_valid_ff)
      else $error("result register loaded while still full");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < eff_w || $past(csr_we))
      else $error("column counter beyond the frame width");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && hit_in && last_in && !csr_we) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters not cleared after the final word of a frame");

endmodule

// ===== hdl/sobel_edge_magnitude_rgb_core.sv =====
// Sobel edge magnitude core on RGB pixels with zero-padded borders. Pixels enter
// in row-major order; each result lags its pixel by one row plus one pixel, and
// flush words (kind 1) drain the last frame_width+1 results. A pixel that yields
// a result passes through accept, store read, window step, check, gradient sums,
// twelve square root steps and the load of the result register, which waits while
// that register is full. A pixel without a result ends after the check; a flush
// word that steps over a position without a result repeats read, step and check.
// The result register lets the next word in while a result waits to be taken.
module sobel_edge_magnitude_rgb_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   sem_req_if.sink                          req_chan,
   sem_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sem_pkg::cmd_type    cmd;
   sem_pkg::status_type status;
   logic                ready;

   assign req_chan.ready = ready;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_red   (req_chan.red_in),
      .req_green (req_chan.green_in),
      .req_blue  (req_chan.blue_in),
      .rsp_chan  (rsp_chan)
   );

endmodule
